/* hdl/sab_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sab_pkg;

    localparam int SLOTS    = 16;
    localparam int STATIONS = 16;
    localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MAP_W    = 16;

    typedef enum logic [1:0] {
        KIND_APPROVE = 2'd0,
        KIND_REJECT  = 2'd1,
        KIND_FORWARD = 2'd2,
        KIND_CONFIRM = 2'd3
    } t_kind;

    typedef struct packed {
        logic [15:0] seq;
        logic [7:0]  src;
        logic [7:0]  dst;
    } t_frame;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  to;
        t_frame      frame;
    } t_msg;

    // set and clear of one slot queue; clear applies before set
    typedef struct packed {
        logic             set;
        logic [IDX_W-1:0] set_idx;
        logic             clr;
        logic [IDX_W-1:0] clr_idx;
    } t_slot_ctl;

endpackage

`default_nettype wire

/* hdl/sab_slot_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module sab_slot_queue (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  sab_pkg::t_slot_ctl            i_ctl,
    input  sab_pkg::t_frame               i_wr_data,
    input  wire  [sab_pkg::IDX_W-1:0]     i_rd_idx,
    output logic                          o_rd_valid,
    output sab_pkg::t_frame               o_rd_data,
    output logic                          o_free_found,
    output logic [sab_pkg::IDX_W-1:0]     o_free_idx
);

    logic [sab_pkg::SLOTS-1:0] r_valid;
    sab_pkg::t_frame           r_pay [sab_pkg::SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_ctl.clr) begin
                r_valid[i_ctl.clr_idx] <= 1'b0;
            end
            if (i_ctl.set) begin
                r_valid[i_ctl.set_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.set) begin
            r_pay[i_ctl.set_idx] <= i_wr_data;
        end
    end

    assign o_rd_valid = r_valid[i_rd_idx];
    assign o_rd_data  = r_pay[i_rd_idx];

    // lowest empty slot
    always_comb begin
        o_free_found = 1'b0;
        o_free_idx   = '0;
        for (int i = sab_pkg::SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                o_free_found = 1'b1;
                o_free_idx   = sab_pkg::IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/sab_out_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module sab_out_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  sab_pkg::t_msg       i_msg,
    input  wire                 i_flush,
    output logic                o_push_ok,
    output logic                o_flush_done,
    output logic                o_tvalid,
    input  wire                 i_tready,
    output sab_pkg::t_msg       o_msg,
    output logic                o_tlast
);

    // hold keeps the newest message until it is known whether another follows
    logic          r_hold_v;
    sab_pkg::t_msg r_hold;
    logic          r_out_v;
    sab_pkg::t_msg r_out;
    logic          r_out_last;
    logic          out_free;
    logic          move;

    assign out_free     = !r_out_v || i_tready;
    assign o_push_ok    = !r_hold_v || out_free;
    assign o_flush_done = !r_hold_v || out_free;
    assign move         = r_hold_v && out_free && (i_push || i_flush);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (move) begin
                r_out_v <= 1'b1;
            end else if (i_tready) begin
                r_out_v <= 1'b0;
            end
            if (i_push) begin
                r_hold_v <= 1'b1;
            end else if (move) begin
                r_hold_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out      <= r_hold;
            r_out_last <= !i_push;
        end
        if (i_push) begin
            r_hold <= i_msg;
        end
    end

    assign o_tvalid = r_out_v;
    assign o_msg    = r_out;
    assign o_tlast  = r_out_last;

endmodule

`default_nettype wire

/* hdl/switch_admission_buffer.sv */
`timescale 1ns / 1ps
`default_nettype none

// One beat at a time: a new beat is accepted only in the idle state, once the last is through.
//   Data, link and ignored beats pass through execute; a request also passes through flush.
// Service tick: setup, a visit to each data slot plus a confirm per forwarded slot,
//   a visit to each request slot until the data slots fill, then flush and idle;
//   output stalls can hold it, as they can hold a request's flush.
// Reset (synchronous, i_rst_n low): both slot queues empty, no station connected.
module switch_admission_buffer (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // [7:0] arrival_port, [23:8] seq_num, [31:24] src_station,
    // [39:32] dst_station, [44:40] station_id, [47:45] zero
    input  wire  [47:0]  s_axis_tdata,
    // [2:0] action
    input  wire  [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // [7:0] to_station, [23:8] out_seq, [31:24] out_src, [39:32] out_dst
    output logic [39:0]  m_axis_tdata,
    // [1:0] msg_kind
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    typedef enum logic [2:0] {
        ACT_REQ  = 3'd0,
        ACT_DATA = 3'd1,
        ACT_TICK = 3'd2,
        ACT_CONN = 3'd3,
        ACT_DISC = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FWD,
        ST_FWD_CONF,
        ST_APR,
        ST_FLUSH
    } t_state;

    localparam logic [sab_pkg::IDX_W-1:0] LAST_IDX = sab_pkg::IDX_W'(sab_pkg::SLOTS - 1);

    t_state                       r_state;
    logic [2:0]                   r_act;
    logic [7:0]                   r_port;
    sab_pkg::t_frame              r_frame;
    logic [4:0]                   r_sid;
    logic [sab_pkg::MAP_W-1:0]    r_map;
    logic [sab_pkg::IDX_W-1:0]    r_idx;

    // slot queues
    sab_pkg::t_slot_ctl           dq_ctl, rq_ctl;
    sab_pkg::t_frame              dq_wr_data;
    logic                         dq_rd_valid, rq_rd_valid;
    sab_pkg::t_frame              dq_rd_data, rq_rd_data;
    logic                         dq_free_found, rq_free_found;
    logic [sab_pkg::IDX_W-1:0]    dq_free_idx, rq_free_idx;

    // output stage
    logic                         push, flush, push_ok, flush_done;
    sab_pkg::t_msg                push_msg, out_msg;

    logic                         sid_ok;
    logic                         dst_conn;

    // station s is valid for 1 <= s <= STATIONS and s <= 16
    assign sid_ok = (r_sid != 5'd0) && ({3'b000, r_sid} <= 8'(sab_pkg::STATIONS))
                    && (r_sid <= 5'd16);

    always_comb begin
        dst_conn = 1'b0;
        if (dq_rd_data.dst != 8'd0 && dq_rd_data.dst <= 8'(sab_pkg::STATIONS)
                && dq_rd_data.dst <= 8'd16) begin
            dst_conn = r_map[4'(dq_rd_data.dst - 8'd1)];
        end
    end

    sab_slot_queue u_data_q (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (dq_ctl),
        .i_wr_data    (dq_wr_data),
        .i_rd_idx     (r_idx),
        .o_rd_valid   (dq_rd_valid),
        .o_rd_data    (dq_rd_data),
        .o_free_found (dq_free_found),
        .o_free_idx   (dq_free_idx)
    );

    sab_slot_queue u_req_q (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (rq_ctl),
        .i_wr_data    (r_frame),
        .i_rd_idx     (r_idx),
        .o_rd_valid   (rq_rd_valid),
        .o_rd_data    (rq_rd_data),
        .o_free_found (rq_free_found),
        .o_free_idx   (rq_free_idx)
    );

    sab_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_msg        (push_msg),
        .i_flush      (flush),
        .o_push_ok    (push_ok),
        .o_flush_done (flush_done),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_msg        (out_msg),
        .o_tlast      (m_axis_tlast)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tdata  = {out_msg.frame.dst, out_msg.frame.src, out_msg.frame.seq, out_msg.to};
    assign m_axis_tuser  = out_msg.kind;

    // sequencer datapath controls
    always_comb begin
        dq_ctl     = '0;
        rq_ctl     = '0;
        dq_wr_data = r_frame;
        push       = 1'b0;
        push_msg   = '{kind: sab_pkg::KIND_APPROVE, to: r_port, frame: r_frame};
        flush      = (r_state == ST_FLUSH);
        unique case (r_state)
            ST_EXEC: begin
                if (r_act == ACT_REQ) begin
                    if (!dq_free_found && !rq_free_found) begin
                        push          = 1'b1;
                        push_msg.kind = sab_pkg::KIND_REJECT;
                    end else if (dq_free_found) begin
                        push = 1'b1;
                    end else begin
                        rq_ctl.set     = 1'b1;
                        rq_ctl.set_idx = rq_free_idx;
                    end
                end else if (r_act == ACT_DATA) begin
                    dq_ctl.set     = dq_free_found;
                    dq_ctl.set_idx = dq_free_idx;
                end
            end
            ST_FWD: begin
                if (dq_rd_valid && dst_conn && push_ok) begin
                    push     = 1'b1;
                    push_msg = '{kind: sab_pkg::KIND_FORWARD, to: dq_rd_data.dst,
                                 frame: dq_rd_data};
                end
            end
            ST_FWD_CONF: begin
                if (push_ok) begin
                    push           = 1'b1;
                    push_msg       = '{kind: sab_pkg::KIND_CONFIRM, to: dq_rd_data.src,
                                       frame: dq_rd_data};
                    dq_ctl.clr     = 1'b1;
                    dq_ctl.clr_idx = r_idx;
                end
            end
            ST_APR: begin
                if (rq_rd_valid && dq_free_found && push_ok) begin
                    push           = 1'b1;
                    push_msg       = '{kind: sab_pkg::KIND_APPROVE, to: rq_rd_data.src,
                                       frame: rq_rd_data};
                    dq_wr_data     = rq_rd_data;
                    dq_ctl.set     = 1'b1;
                    dq_ctl.set_idx = dq_free_idx;
                    rq_ctl.clr     = 1'b1;
                    rq_ctl.clr_idx = r_idx;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_map   <= '0;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_idx <= '0;
                    priority case (r_act)
                        ACT_REQ:  r_state <= ST_FLUSH;
                        ACT_TICK: r_state <= ST_FWD;
                        ACT_CONN: begin
                            if (sid_ok) r_map[4'(r_sid - 5'd1)] <= 1'b1;
                            r_state <= ST_IDLE;
                        end
                        ACT_DISC: begin
                            if (sid_ok) r_map[4'(r_sid - 5'd1)] <= 1'b0;
                            r_state <= ST_IDLE;
                        end
                        default:  r_state <= ST_IDLE;
                    endcase
                end
                ST_FWD: begin
                    if (dq_rd_valid && dst_conn) begin
                        if (push_ok) r_state <= ST_FWD_CONF;
                    end else if (r_idx == LAST_IDX) begin
                        r_idx   <= '0;
                        r_state <= ST_APR;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_FWD_CONF: begin
                    if (push_ok) begin
                        if (r_idx == LAST_IDX) begin
                            r_idx   <= '0;
                            r_state <= ST_APR;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= ST_FWD;
                        end
                    end
                end
                ST_APR: begin
                    if (rq_rd_valid && !dq_free_found) begin
                        r_state <= ST_FLUSH;
                    end else if (!rq_rd_valid || push_ok) begin
                        if (r_idx == LAST_IDX) begin
                            r_state <= ST_FLUSH;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (flush_done) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // input beat capture
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_act         <= s_axis_tuser;
            r_port        <= s_axis_tdata[7:0];
            r_frame.seq   <= s_axis_tdata[23:8];
            r_frame.src   <= s_axis_tdata[31:24];
            r_frame.dst   <= s_axis_tdata[39:32];
            r_sid         <= s_axis_tdata[44:40];
        end
    end

endmodule

`default_nettype wire
